FILE: rtl/core/tcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token class recognizer package
// Shared widths, state vector layout, character codes and class codes.
// ----------------------------------------------------------------------------
package tcr_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned CLASS_W = 3;
   localparam int unsigned NFA_W   = 41;

   localparam int unsigned OFF_SOIT    = 0;
   localparam int unsigned OFF_DANS    = 5;
   localparam int unsigned OFF_ASSIGN  = 10;
   localparam int unsigned OFF_COMPLEX = 13;
   localparam int unsigned OFF_REAL    = 30;
   localparam int unsigned OFF_INTEGER = 34;
   localparam int unsigned OFF_IDENT   = 39;

   typedef logic [NFA_W-1:0]   nfa_vec_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [CLASS_W-1:0] class_type;

   localparam nfa_vec_type NFA_INIT =
      (NFA_W'(1) << OFF_SOIT)    | (NFA_W'(1) << OFF_DANS)    |
      (NFA_W'(1) << OFF_ASSIGN)  | (NFA_W'(1) << OFF_COMPLEX) |
      (NFA_W'(1) << OFF_REAL)    | (NFA_W'(1) << OFF_INTEGER) |
      (NFA_W'(1) << OFF_IDENT);

   localparam char_type CH_UP_S   = 8'h53;
   localparam char_type CH_UP_O   = 8'h4F;
   localparam char_type CH_UP_I   = 8'h49;
   localparam char_type CH_UP_T   = 8'h54;
   localparam char_type CH_LO_D   = 8'h64;
   localparam char_type CH_LO_A   = 8'h61;
   localparam char_type CH_LO_N   = 8'h6E;
   localparam char_type CH_LO_S   = 8'h73;
   localparam char_type CH_LO_I   = 8'h69;
   localparam char_type CH_LO_Z   = 8'h7A;
   localparam char_type CH_UP_A   = 8'h41;
   localparam char_type CH_UP_Z   = 8'h5A;
   localparam char_type CH_LESS   = 8'h3C;
   localparam char_type CH_MINUS  = 8'h2D;
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_DOT    = 8'h2E;
   localparam char_type CH_UNDER  = 8'h5F;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_NINE   = 8'h39;

   localparam class_type CLS_NONE    = 3'd0;
   localparam class_type CLS_SOIT    = 3'd1;
   localparam class_type CLS_DANS    = 3'd2;
   localparam class_type CLS_ASSIGN  = 3'd3;
   localparam class_type CLS_COMPLEX = 3'd4;
   localparam class_type CLS_REAL    = 3'd5;
   localparam class_type CLS_INTEGER = 3'd6;
   localparam class_type CLS_IDENT   = 3'd7;

endpackage
`default_nettype wire

FILE: rtl/core/token_class_recognizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token class recognizer
// Classifies a token streamed one character per request, with seven NFAs.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and updates all seven recognizer
// state vectors in a single 41-bit register in that same cycle. The request
// flagged as the last character of a token yields one response in the next
// cycle, held in an output register; other requests yield none. Requests
// are stalled only while that output register holds a response that is
// itself stalled, so throughput is one character per cycle.
// ----------------------------------------------------------------------------
module token_class_recognizer
   import tcr_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire char_type    req_char_code,
   input  wire              req_last_of_token,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output class_type        rsp_token_class
);

   nfa_vec_type state_ff;
   nfa_vec_type state_in;
   nfa_vec_type step_vec;
   class_type   step_class;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   class_type   rsp_class_ff;
   class_type   rsp_class_in;
   logic        req_accept;

   tcr_nfa_step u_step (
      .cur_vec     (state_ff),
      .char_code   (req_char_code),
      .next_vec    (step_vec),
      .token_class (step_class)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_class_in = rsp_class_ff;
      if (req_accept) begin
         if (req_last_of_token) begin
            state_in     = NFA_INIT;
            rsp_valid_in = 1'b1;
            rsp_class_in = step_class;
         end else begin
            state_in = step_vec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= NFA_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_class = rsp_class_ff;

endmodule
`default_nettype wire

FILE: rtl/core/tcr_nfa_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token class recognizer NFA step
// Advances all seven state vectors by one character and picks the class.
// ----------------------------------------------------------------------------
module tcr_nfa_step
   import tcr_pkg::*;
(
   input  wire nfa_vec_type cur_vec,
   input  wire char_type    char_code,
   output nfa_vec_type      next_vec,
   output class_type        token_class
);

   logic             is_digit;
   logic             is_letter;
   logic [4:0]       v_soit;
   logic [4:0]       v_dans;
   logic [2:0]       v_asg;
   logic [16:0]      v_cpx;
   logic [3:0]       v_real;
   logic [4:0]       v_int;
   logic [1:0]       v_id;
   logic [4:0]       n_soit;
   logic [4:0]       n_dans;
   logic [2:0]       n_asg;
   logic [16:0]      n_cpx;
   logic [3:0]       n_real;
   logic [4:0]       n_int;
   logic [1:0]       n_id;

   assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_letter = ((char_code >= CH_LO_A) && (char_code <= CH_LO_Z)) ||
                      ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z)) ||
                      (char_code == CH_UNDER);

   assign v_soit = cur_vec[OFF_SOIT    +: 5];
   assign v_dans = cur_vec[OFF_DANS    +: 5];
   assign v_asg  = cur_vec[OFF_ASSIGN  +: 3];
   assign v_cpx  = cur_vec[OFF_COMPLEX +: 17];
   assign v_real = cur_vec[OFF_REAL    +: 4];
   assign v_int  = cur_vec[OFF_INTEGER +: 5];
   assign v_id   = cur_vec[OFF_IDENT   +: 2];

   assign n_soit = {v_soit[3] && (char_code == CH_UP_T),
                    v_soit[2] && (char_code == CH_UP_I),
                    v_soit[1] && (char_code == CH_UP_O),
                    v_soit[0] && (char_code == CH_UP_S),
                    1'b0};

   assign n_dans = {v_dans[3] && (char_code == CH_LO_S),
                    v_dans[2] && (char_code == CH_LO_N),
                    v_dans[1] && (char_code == CH_LO_A),
                    v_dans[0] && (char_code == CH_LO_D),
                    1'b0};

   assign n_asg = {v_asg[1] && (char_code == CH_MINUS),
                   v_asg[0] && (char_code == CH_LESS),
                   1'b0};

   always_comb begin
      n_cpx = '0;
      if (is_digit) begin
         if (v_cpx[0] || v_cpx[1]) n_cpx[1] = 1'b1;
         if (v_cpx[3] || v_cpx[4]) n_cpx[4] = 1'b1;
         if (v_cpx[10] || v_cpx[11]) n_cpx[11] = 1'b1;
         if (v_cpx[13] || v_cpx[14]) n_cpx[14] = 1'b1;
      end
      if (char_code == CH_DOT) begin
         if (v_cpx[2]) n_cpx[3] = 1'b1;
         if (v_cpx[12]) n_cpx[13] = 1'b1;
      end
      if ((char_code == CH_MINUS) && v_cpx[6]) n_cpx[7] = 1'b1;
      if ((char_code == CH_PLUS) && v_cpx[8]) n_cpx[9] = 1'b1;
      if ((char_code == CH_LO_I) && v_cpx[15]) n_cpx[16] = 1'b1;
      // Epsilon closure; every epsilon move goes to a higher state.
      if (n_cpx[1]) begin
         n_cpx[2] = 1'b1;
         n_cpx[5] = 1'b1;
      end
      if (n_cpx[4]) n_cpx[5] = 1'b1;
      if (n_cpx[5]) begin
         n_cpx[6] = 1'b1;
         n_cpx[8] = 1'b1;
      end
      if (n_cpx[7] || n_cpx[9]) n_cpx[10] = 1'b1;
      if (n_cpx[11]) begin
         n_cpx[12] = 1'b1;
         n_cpx[15] = 1'b1;
      end
      if (n_cpx[14]) n_cpx[15] = 1'b1;
   end

   always_comb begin
      n_real = '0;
      if (is_digit) begin
         if (v_real[0] || v_real[1]) n_real[1] = 1'b1;
         if (v_real[2] || v_real[3]) n_real[3] = 1'b1;
      end
      if ((char_code == CH_DOT) && v_real[1]) n_real[2] = 1'b1;
   end

   always_comb begin
      n_int = '0;
      if (is_digit) begin
         if (v_int[0]) n_int[1] = 1'b1;
         if (v_int[2]) n_int[3] = 1'b1;
      end
      if (n_int[1] || n_int[3]) begin
         n_int[2] = 1'b1;
         n_int[4] = 1'b1;
      end
   end

   assign n_id = {(v_id[0] && is_letter) || (v_id[1] && (is_letter || is_digit)), 1'b0};

   assign next_vec = {n_id, n_int, n_real, n_cpx, n_asg, n_dans, n_soit};

   always_comb begin
      if (n_soit[4]) token_class = CLS_SOIT;
      else if (n_dans[4]) token_class = CLS_DANS;
      else if (n_asg[2]) token_class = CLS_ASSIGN;
      else if (n_cpx[16]) token_class = CLS_COMPLEX;
      else if (n_real[3]) token_class = CLS_REAL;
      else if (n_int[4]) token_class = CLS_INTEGER;
      else if (n_id[1]) token_class = CLS_IDENT;
      else token_class = CLS_NONE;
   end

endmodule
`default_nettype wire
